### rtl/armdb_pkg.sv
package armdb_pkg;

   localparam int SUM_W       = 51;
   localparam int LEVEL_W     = 18;
   localparam int WIN_W       = 16;
   localparam int OFFSET_W    = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 18;
   localparam int DB_OUT_W    = 16;
   localparam int ROUND_W     = 8;
   localparam int ROOT_W      = 26;
   localparam int FRAC_W      = 24;
   localparam int LOG_Y_W     = 31;
   localparam int EXP_W       = 5;
   localparam int LOG_W       = EXP_W + FRAC_W;
   localparam int DB_COEF_W   = 27;
   localparam int DB_PROD_W   = LOG_W + DB_COEF_W;
   localparam int STEP_CNT_W  = 6;

   localparam int DIV_STEPS   = SUM_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int LOG_STEPS   = FRAC_W;

   localparam logic [LEVEL_W-1:0]   FULL_SCALE   = 18'd131072;
   localparam logic [SUM_W-1:0]     SUM_MAX      = {SUM_W{1'b1}};
   // 20*log10(2) in Q24
   localparam logic [DB_COEF_W-1:0] DB_PER_LOG2  = 27'd101008905;
   localparam int                   DB_MAX_WHOLE = 130;
   localparam int                   LOG_E_MAX    = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RMS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DB_OFFSET = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_OK   = 2'd3;

   localparam logic OPC_SAMPLE = 1'b0;
   localparam logic OPC_TICK   = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] raw_word;
   } req_word_type;

   typedef struct packed {
      logic                reading_ok;
      logic [LEVEL_W-1:0]  rms_level;
      logic [LEVEL_W-1:0]  peak_level;
      logic [DB_OUT_W-1:0] level_db_q8;
      logic [ROUND_W-1:0]  level_db_round;
   } rsp_word_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_SAMPLE_LOAD,
      OP_SQUARE,
      OP_ACCUM,
      OP_TICK,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_RMS,
      OP_LOG_INIT,
      OP_LOG_STEP,
      OP_DB_MUL,
      OP_DB_FIN,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic count_full;
      logic tick_close;
      logic db_skip;
   } status_type;

endpackage

### rtl/armdb_ctrl.sv
module armdb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  armdb_pkg::status_type status,
   output armdb_pkg::cmd_type   cmd
);
   import armdb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIV_INIT,
      ST_DIV,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_RMS,
      ST_LOG_INIT,
      ST_LOG,
      ST_DB_MUL,
      ST_DB_FIN,
      ST_PUBLISH
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.op       = OP_NOP;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OPC_TICK) begin
                  cmd.op = OP_TICK;
                  if (status.tick_close) state_in = ST_DIV_INIT;
               end else if (!status.count_full) begin
                  cmd.op   = OP_SAMPLE_LOAD;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            cmd.op   = OP_SQUARE;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.op   = OP_ACCUM;
            state_in = ST_IDLE;
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_CNT_W'(DIV_STEPS - 1)) state_in = ST_SQRT_INIT;
         end
         ST_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op  = OP_SQRT_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_CNT_W'(SQRT_STEPS - 1)) state_in = ST_RMS;
         end
         ST_RMS: begin
            cmd.op   = OP_RMS;
            state_in = ST_LOG_INIT;
         end
         ST_LOG_INIT: begin
            // rms now registered: skip the log when no dB is due
            cmd.op   = status.db_skip ? OP_NOP : OP_LOG_INIT;
            step_in  = '0;
            state_in = status.db_skip ? ST_DB_FIN : ST_LOG;
         end
         ST_LOG: begin
            cmd.op  = OP_LOG_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_CNT_W'(LOG_STEPS - 1)) state_in = ST_DB_MUL;
         end
         ST_DB_MUL: begin
            cmd.op   = OP_DB_MUL;
            state_in = ST_DB_FIN;
         end
         ST_DB_FIN: begin
            cmd.op   = OP_DB_FIN;
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (out_free) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/armdb_dp.sv
module armdb_dp #(
   parameter int COUNT_BITS   = 16,
   parameter int SAMPLE_SHIFT = 14,
   parameter int DB_FRAC_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  armdb_pkg::cmd_type                      cmd,
   output armdb_pkg::status_type                   status,
   input  logic signed [31:0]                      req_raw_word,
   input  logic                                    csr_we,
   input  logic [armdb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [armdb_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output armdb_pkg::rsp_word_type                 rsp_data
);
   import armdb_pkg::*;

   localparam int MAG_W    = 33 - SAMPLE_SHIFT;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int ADD_W    = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
   localparam int DB_W     = DB_FRAC_BITS + 8;
   localparam int DB_SHIFT = 48 - DB_FRAC_BITS;
   localparam int CALC_W   = 60;
   localparam logic [CALC_W-1:0] DB_BIAS =
      (CALC_W'(LOG_E_MAX) * CALC_W'(DB_PER_LOG2)) << FRAC_W;
   localparam logic [CALC_W-1:0] DB_HALF = CALC_W'(1) << (DB_SHIFT - 1);
   localparam logic [DB_W-1:0]   DB_MAX  = DB_W'(DB_MAX_WHOLE) << DB_FRAC_BITS;

   // configuration
   logic [WIN_W-1:0]           window_ms_ff;
   logic [LEVEL_W-1:0]         min_rms_ff;
   logic signed [OFFSET_W-1:0] db_offset_ff;
   logic                       link_ok_ff;

   // window state
   logic [SUM_W-1:0]      sum_ff;
   logic [LEVEL_W-1:0]    peak_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [WIN_W-1:0]      tick_ff;
   logic [WIN_W-1:0]      tick_next;

   // sample path
   logic [MAG_W-1:0] mag_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic [32:0]      neg_mag;
   logic [32:0]      mag_full;
   logic [ADD_W-1:0] sum_add;
   logic [LEVEL_W-1:0] mag_clamp;

   // divider
   logic [SUM_W-1:0]      quo_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [COUNT_BITS:0]   div_trial;

   // square root
   logic [SUM_W:0]    sop_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W+1:0] srem_ff;
   logic [ROOT_W+1:0] srem_trial;
   logic [ROOT_W+1:0] root_trial;
   logic [LEVEL_W-1:0] rms_ff;

   // log and dB
   logic [EXP_W-1:0]       exp_ff;
   logic [EXP_W-1:0]       exp_lead;
   logic [LOG_Y_W-1:0]     y_ff;
   logic [FRAC_W-1:0]      frac_ff;
   logic [2*LOG_Y_W-1:0]   y_sq;
   logic [LOG_Y_W:0]       y_top;
   logic [DB_PROD_W-1:0]   prod_ff;
   logic signed [CALC_W-1:0] db_val;
   logic signed [CALC_W-1:0] db_sum;
   logic [DB_W-1:0]        db_ff;
   logic [DB_W:0]          db_round;

   rsp_word_type out_ff;

   // magnitude of the shifted word, negative side rounds toward larger magnitude
   always_comb begin
      neg_mag  = 33'h1_0000_0000 - {1'b0, req_raw_word};
      if (req_raw_word[31]) begin
         mag_full = (neg_mag + 33'((64'd1 << SAMPLE_SHIFT) - 64'd1)) >> SAMPLE_SHIFT;
      end else begin
         mag_full = {1'b0, req_raw_word} >> SAMPLE_SHIFT;
      end
   end

   assign sum_add   = ADD_W'(sum_ff) + ADD_W'(sq_ff);
   assign mag_clamp = (33'(mag_ff) > 33'(FULL_SCALE)) ? FULL_SCALE : LEVEL_W'(mag_ff);
   assign tick_next = tick_ff + 1'b1;

   assign div_trial  = {rem_ff, quo_ff[SUM_W-1]};
   assign srem_trial = {srem_ff[ROOT_W-1:0], sop_ff[SUM_W:SUM_W-1]};
   assign root_trial = {root_ff, 2'b01};

   always_comb begin
      exp_lead = '0;
      for (int i = 1; i <= LOG_E_MAX; i++) begin
         if (rms_ff[i]) exp_lead = EXP_W'(i);
      end
   end

   assign y_sq  = (2*LOG_Y_W)'(y_ff) * (2*LOG_Y_W)'(y_ff);
   assign y_top = y_sq[2*LOG_Y_W-1:LOG_Y_W-1];

   always_comb begin
      db_val = $signed({{(CALC_W-DB_PROD_W){1'b0}}, prod_ff}) - $signed(DB_BIAS)
               + $signed(DB_HALF);
      db_sum = (db_val >>> DB_SHIFT) + CALC_W'(db_offset_ff);
   end

   assign db_round = ({1'b0, db_ff} + (DB_W+1)'(1 << (DB_FRAC_BITS - 1))) >> DB_FRAC_BITS;

   assign status.count_full = &count_ff;
   assign status.tick_close = (tick_next >= window_ms_ff);
   assign status.db_skip    = !((rms_ff >= min_rms_ff) && (rms_ff != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff <= 16'd1000;
         min_rms_ff   <= 18'd1;
         db_offset_ff <= 17'sd30720;
         link_ok_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_MS: window_ms_ff <= csr_wdata[WIN_W-1:0];
            CSR_MIN_RMS:   min_rms_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_DB_OFFSET: db_offset_ff <= $signed(csr_wdata[OFFSET_W-1:0]);
            CSR_LINK_OK:   link_ok_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         peak_ff  <= '0;
         count_ff <= '0;
         tick_ff  <= '0;
      end else begin
         case (cmd.op)
            OP_ACCUM: begin
               sum_ff   <= (sum_add > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
               if (mag_clamp > peak_ff) peak_ff <= mag_clamp;
               count_ff <= count_ff + 1'b1;
            end
            OP_TICK: begin
               tick_ff <= status.tick_close ? '0 : tick_next;
            end
            OP_PUBLISH: begin
               sum_ff   <= '0;
               peak_ff  <= '0;
               count_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_SAMPLE_LOAD: mag_ff <= mag_full[MAG_W-1:0];
         OP_SQUARE:      sq_ff  <= SQ_W'(mag_ff) * SQ_W'(mag_ff);
         OP_DIV_INIT: begin
            quo_ff <= sum_ff;
            rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (div_trial >= {1'b0, count_ff}) begin
               rem_ff <= COUNT_BITS'(div_trial - {1'b0, count_ff});
               quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= div_trial[COUNT_BITS-1:0];
               quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
            end
         end
         OP_SQRT_INIT: begin
            sop_ff  <= {1'b0, quo_ff};
            root_ff <= '0;
            srem_ff <= '0;
         end
         OP_SQRT_STEP: begin
            sop_ff <= {sop_ff[SUM_W-2:0], 2'b00};
            if (srem_trial >= root_trial) begin
               srem_ff <= srem_trial - root_trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff <= srem_trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_RMS: begin
            if (count_ff == '0) begin
               rms_ff <= '0;
            end else if (root_ff > ROOT_W'(FULL_SCALE)) begin
               rms_ff <= FULL_SCALE;
            end else begin
               rms_ff <= root_ff[LEVEL_W-1:0];
            end
         end
         OP_LOG_INIT: begin
            exp_ff  <= exp_lead;
            y_ff    <= LOG_Y_W'({{(LOG_Y_W-LEVEL_W){1'b0}}, rms_ff} << (5'd30 - exp_lead));
            frac_ff <= '0;
         end
         OP_LOG_STEP: begin
            // y stays in [1,2) as Q30; a square at or past 2 yields a one bit
            if (y_top[LOG_Y_W]) begin
               y_ff    <= y_top[LOG_Y_W:1];
               frac_ff <= {frac_ff[FRAC_W-2:0], 1'b1};
            end else begin
               y_ff    <= y_top[LOG_Y_W-1:0];
               frac_ff <= {frac_ff[FRAC_W-2:0], 1'b0};
            end
         end
         OP_DB_MUL: prod_ff <= DB_PROD_W'({exp_ff, frac_ff}) * DB_PROD_W'(DB_PER_LOG2);
         OP_DB_FIN: begin
            if (status.db_skip || db_sum < 0) begin
               db_ff <= '0;
            end else if (db_sum > $signed(CALC_W'(DB_MAX))) begin
               db_ff <= DB_MAX;
            end else begin
               db_ff <= db_sum[DB_W-1:0];
            end
         end
         OP_PUBLISH: begin
            out_ff.reading_ok     <= link_ok_ff && (count_ff != '0);
            out_ff.rms_level      <= rms_ff;
            out_ff.peak_level     <= peak_ff;
            out_ff.level_db_q8    <= DB_OUT_W'(db_ff);
            out_ff.level_db_round <= db_round[ROUND_W-1:0];
         end
         default: ;
      endcase
   end

   assign rsp_data = out_ff;

endmodule

### rtl/audio_rms_peak_db_meter.sv
// Sound level meter. Sample words (opcode 0) are scaled to a Q1.17 magnitude
// whose square goes into a saturating window sum, while the window peak and
// sample count are kept; once the count is full, further samples are dropped.
// Millisecond ticks (opcode 1) advance the window counter; the tick that
// reaches window_ms yields one result word with rms, peak and the dB level in
// Q8 and whole dB, then clears the window. A sample is loaded, squared and
// accumulated (once the count is full it is only taken). A closing tick's
// word is formed by a 51-step restoring divider for the mean square, a
// 26-step square root, and, unless no dB is due, 24 square-and-compare steps
// of the log2 unit on one 31x31 multiplier. A waiting result word does not
// block samples or ticks; only the next closing tick waits for it to be
// taken.
module audio_rms_peak_db_meter #(
   parameter int COUNT_BITS   = 16,
   parameter int SAMPLE_SHIFT = 14,
   parameter int DB_FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  armdb_pkg::req_word_type           req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output armdb_pkg::rsp_word_type           rsp_data,
   input  logic                              csr_we,
   input  logic [armdb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [armdb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import armdb_pkg::*;

   cmd_type    cmd;
   status_type status;

   armdb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   armdb_dp #(
      .COUNT_BITS   (COUNT_BITS),
      .SAMPLE_SHIFT (SAMPLE_SHIFT),
      .DB_FRAC_BITS (DB_FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_raw_word (req_data.raw_word),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_data     (rsp_data)
   );

   // a new word never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |-> (!rsp_valid || !rsp_stall))
      else $error("result word overwritten while stalled");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |=> rsp_valid)
      else $error("published word not offered");

   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.peak_level <= FULL_SCALE &&
                     rsp_data.rms_level <= FULL_SCALE))
      else $error("level above full scale");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_STEP || cmd.op == OP_LOG_STEP) |-> req_stall)
      else $error("input taken during window close");

endmodule

### verif/audio_rms_peak_db_meter_tb.sv
module audio_rms_peak_db_meter_tb;
   import armdb_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int CLOSE_CYCLES   = 200;

   typedef struct {
      bit             opcode;
      logic [31:0]    raw;
      bit             known;
      rsp_word_type   want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_WINDOW_MS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // meter state and settings as predicted
   logic [63:0]  win_len, floor_rms, link_up;
   longint       db_ofs;
   logic [63:0]  sum_sq, peak_mag, n_samples, n_ticks;

   rsp_word_type readings_due[$];
   stim_row_type dir_rows[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   int           rsp_hold = 0;
   bit           gaps_on = 1'b1;

   audio_rms_peak_db_meter dut (.*);

   always #1 clock = ~clock;

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] log2_fix(logic [63:0] r);
      logic [63:0] e, y, frac;
      e = 0;
      frac = 0;
      while (e < 17 && (r >> (e + 1)) != 0) e++;
      y = r << (30 - e);
      for (int i = 0; i < 24; i++) begin
         y = (y * y) >> 30;
         frac = frac << 1;
         if (y >= (64'd2 << 30)) begin
            y = y >> 1;
            frac = frac | 1;
         end
      end
      return (e << 24) | frac;
   endfunction

   function automatic longint rms_to_db(logic [63:0] rms);
      logic [63:0] p, biased, q;
      p = log2_fix(rms) * 64'd101008905;
      biased = p + (64'd128 << 48) - ((64'd17 * 64'd101008905) << 24);
      q = (biased + (64'd1 << 39)) >> 40;
      return longint'(q) - (longint'(128) << 8);
   endfunction

   // advances the meter state; returns 1 when a reading is produced
   function automatic bit meter_step(req_word_type w, output rsp_word_type r);
      logic [63:0] x, mag, sq, rms;
      longint      db;
      x = {32'd0, w.raw_word};
      r = '0;
      if (w.opcode == OPC_SAMPLE) begin
         if (n_samples >= 64'hFFFF) return 1'b0;
         if (x[31]) mag = ((64'h1_0000_0000 - x) + 16383) >> 14;
         else mag = x >> 14;
         sq = mag * mag;
         sum_sq = (sq > ((64'd1 << 51) - 1) - sum_sq) ? (64'd1 << 51) - 1 : sum_sq + sq;
         if (mag > 131072) mag = 131072;
         if (mag > peak_mag) peak_mag = mag;
         n_samples++;
         return 1'b0;
      end
      n_ticks = (n_ticks + 1) & 64'hFFFF;
      if (n_ticks < win_len) return 1'b0;
      rms = 0;
      db = 0;
      if (n_samples != 0) begin
         rms = int_sqrt(sum_sq / n_samples);
         if (rms > 131072) rms = 131072;
      end
      if (rms >= floor_rms && rms != 0) db = rms_to_db(rms) + db_ofs;
      if (db < 0) db = 0;
      if (db > (130 << 8)) db = 130 << 8;
      r.reading_ok     = link_up[0] && n_samples != 0;
      r.rms_level      = rms[LEVEL_W-1:0];
      r.peak_level     = peak_mag[LEVEL_W-1:0];
      r.level_db_q8    = db[15:0];
      r.level_db_round = 8'((db + 128) >> 8);
      sum_sq = 0;
      peak_mag = 0;
      n_samples = 0;
      n_ticks = 0;
      return 1'b1;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_WINDOW_MS: win_len = 64'(val[15:0]);
         CSR_MIN_RMS:   floor_rms = 64'(val);
         CSR_DB_OFFSET: db_ofs = longint'($signed(val[16:0]));
         default:       link_up = 64'(val[0]);
      endcase
   endtask

   task automatic configure(int win, int min_rms, int ofs, int link);
      // stop offering the last word before waiting for the meter to drain
      @(negedge clock);
      req_valid <= 1'b0;
      wait (readings_due.size() == 0);
      repeat (CLOSE_CYCLES) @(negedge clock);
      csr_write(CSR_WINDOW_MS, CSR_DATA_W'(win));
      csr_write(CSR_MIN_RMS, CSR_DATA_W'(min_rms));
      csr_write(CSR_DB_OFFSET, CSR_DATA_W'(ofs[16:0]));
      csr_write(CSR_LINK_OK, CSR_DATA_W'(link));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // offers one word and waits for it to be taken; known rows carry their own reading
   task automatic send_word(req_word_type w, bit known = 0,
                            rsp_word_type want = '0);
      rsp_word_type r;
      int           gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      if (meter_step(w, r)) readings_due.push_back(known ? want : r);
   endtask

   function automatic req_word_type random_word(int tick_odds);
      req_word_type w;
      w.opcode = ($urandom_range(0, 99) < tick_odds) ? OPC_TICK : OPC_SAMPLE;
      case ($urandom_range(0, 5))
         0:       w.raw_word = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         1:       w.raw_word = 32'($signed(20'($urandom)));
         2:       w.raw_word = 32'($signed(26'($urandom)));
         default: w.raw_word = $urandom;
      endcase
      return w;
   endfunction

   function automatic void add_row(bit opc, logic [31:0] raw, bit known = 0,
                                   rsp_word_type want = '0);
      stim_row_type s;
      s.opcode = opc;
      s.raw = raw;
      s.known = known;
      s.want = want;
      dir_rows.push_back(s);
   endfunction

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readings_due.size() == 0) begin
            $error("reading with none expected: %p", rsp_data);
            error_count++;
         end else begin
            e = readings_due.pop_front();
            if (rsp_data.reading_ok !== e.reading_ok) begin
               $error("reading_ok exp %0d got %0d", e.reading_ok, rsp_data.reading_ok);
               error_count++;
            end
            if (rsp_data.rms_level !== e.rms_level) begin
               $error("rms_level exp %0d got %0d", e.rms_level, rsp_data.rms_level);
               error_count++;
            end
            if (rsp_data.peak_level !== e.peak_level) begin
               $error("peak_level exp %0d got %0d", e.peak_level, rsp_data.peak_level);
               error_count++;
            end
            if (rsp_data.level_db_q8 !== e.level_db_q8) begin
               $error("level_db_q8 exp %0d got %0d", e.level_db_q8, rsp_data.level_db_q8);
               error_count++;
            end
            if (rsp_data.level_db_round !== e.level_db_round) begin
               $error("level_db_round exp %0d got %0d", e.level_db_round,
                      rsp_data.level_db_round);
               error_count++;
            end
         end
         rsp_hold <= gaps_on ? $urandom_range(0, 5) : 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("audio_rms_peak_db_meter regression: fail");
            $finish;
         end
      end
   end

   initial begin
      req_word_type w;
      win_len = 1000;
      floor_rms = 1;
      db_ofs = 30720;
      link_up = 1;
      sum_sq = 0;
      peak_mag = 0;
      n_samples = 0;
      n_ticks = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one window per tick; reset values for the other settings
      configure(1, 1, 30720, 1);
      // empty window
      add_row(OPC_TICK, 0, 1, '{1'b0, 18'd0, 18'd0, 16'd0, 8'd0});
      // most negative word is exactly full scale
      add_row(OPC_SAMPLE, 32'h8000_0000);
      add_row(OPC_TICK, 0, 1, '{1'b1, 18'd131072, 18'd131072, 16'd30720, 8'd120});
      add_row(OPC_SAMPLE, 32'h7FFF_FFFF);
      add_row(OPC_TICK, 0);
      // magnitude truncates to zero: rms below threshold
      add_row(OPC_SAMPLE, 32'h0000_3FFF);
      add_row(OPC_TICK, 0, 1, '{1'b1, 18'd0, 18'd0, 16'd0, 8'd0});
      // small negative rounds away from zero
      add_row(OPC_SAMPLE, 32'hFFFF_FFFF);
      add_row(OPC_TICK, 0);
      add_row(OPC_SAMPLE, 32'h0000_4000);
      add_row(OPC_SAMPLE, 32'h1234_5678);
      add_row(OPC_SAMPLE, 32'hC000_0000);
      add_row(OPC_SAMPLE, 32'h5555_AAAA);
      add_row(OPC_TICK, 0);
      add_row(OPC_TICK, 0, 1, '{1'b0, 18'd0, 18'd0, 16'd0, 8'd0});
      foreach (dir_rows[i]) begin
         w.opcode = dir_rows[i].opcode;
         w.raw_word = dir_rows[i].raw;
         send_word(w, dir_rows[i].known, dir_rows[i].want);
      end

      // min threshold zero with zero rms, link down, window zero, offset extremes
      configure(3, 0, 0, 1);
      repeat (250) send_word(random_word(25));
      configure(0, 131072, -32768, 0);
      repeat (150) send_word(random_word(30));
      configure(5, 100, 65535, 1);
      gaps_on = 0;
      repeat (200) send_word(random_word(20));
      gaps_on = 1;
      configure(8, 1, 30720, 1);
      repeat (250) send_word(random_word(15));
      configure(2, 2000, -5000, 1);
      repeat (150) send_word(random_word(35));

      @(negedge clock);
      req_valid <= 1'b0;
      wait (readings_due.size() == 0);
      repeat (CLOSE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("audio_rms_peak_db_meter regression: pass");
      end else begin
         $display("audio_rms_peak_db_meter regression: fail");
      end
      $finish;
   end
endmodule
